### sv/rfa_pkg.sv
// Package for the rational fraction ALU: widths, opcodes and status codes.
package rfa_pkg;
    localparam int DEF_WIDTH = 16;
    localparam int FLD_W = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_DENZERO = 2'd2
    } status_t;

    // command and status between the sequencer and the divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

### sv/rfa_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
module rfa_div
    import rfa_pkg::*;
#(
    parameter int W = 34
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output div_ctl_t     ctl,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign ctl       = '{start: start, busy: busy_reg, done: done_reg};
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

### sv/rational_fraction_alu.sv
// Rational fraction ALU: cross-multiply, Euclid gcd, reduce and normalise sign.
// Sequence: two or three multiply steps, then (k+2) divider runs for a gcd of k remainder
// steps (gcd, then numerator and denominator quotients), plus control states.
// Flow: one word at a time; s_tready is high only when idle and no result waits.
// The shared bit-serial divider dominates the run time. Error cases go straight to the result.
// Reset: rst_n asynchronous, active low, returns the sequencer to idle.
module rational_fraction_alu
    import rfa_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // a_num, a_den, b_num, b_den (16 bits each)
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // res_num (33), res_den (31)
    output logic [1:0]  m_tuser    // status
);
    localparam int PW = 2 * WIDTH;
    localparam int MW = PW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_GSTART, S_GWAIT,
        S_NSTART, S_NWAIT, S_DSTART, S_DWAIT, S_OUT
    } state_t;

    state_t          state_reg;
    logic [1:0]      op_reg;
    logic            an_s, ad_s, bn_s, bd_s;
    logic [WIDTH:0]  an_m, ad_m, bn_m, bd_m;
    logic [WIDTH:0]  ma_reg, mb_reg;
    logic [PW+1:0]   prod;
    logic [PW+1:0]   p1_reg;
    logic            p1n_reg;
    logic [MW-1:0]   num_reg, den_reg, gx_reg, gy_reg, nq_reg;
    logic            numn_reg, denn_reg;
    logic            dv_start;
    logic [MW-1:0]   dv_a, dv_b, dv_q, dv_r;
    div_ctl_t        dv_ctl;
    logic [NUM_W-1:0] rn_reg;
    logic [DEN_W-1:0] rd_reg;
    logic [1:0]      st_reg;
    logic [NUM_W-1:0] negn;
    logic [PW+1:0]   t1, t2;
    logic            n1, n2, sgn;
    logic [MW-1:0]   sum_mag;
    logic            sum_neg;

    function automatic logic [WIDTH:0] fmag(input logic [FLD_W-1:0] f);
        logic [WIDTH-1:0] v;
        v = WIDTH'(f);
        fmag = v[WIDTH-1] ? ((WIDTH+1)'(1) << WIDTH) - {1'b0, v} : {1'b0, v};
    endfunction

    function automatic logic fneg(input logic [FLD_W-1:0] f);
        logic [WIDTH-1:0] v;
        v = WIDTH'(f);
        fneg = v[WIDTH-1];
    endfunction

    assign an_s = fneg(s_tdata[FLD_W-1:0]);
    assign ad_s = fneg(s_tdata[2*FLD_W-1:FLD_W]);
    assign bn_s = fneg(s_tdata[3*FLD_W-1:2*FLD_W]);
    assign bd_s = fneg(s_tdata[4*FLD_W-1:3*FLD_W]);
    assign an_m = fmag(s_tdata[FLD_W-1:0]);
    assign ad_m = fmag(s_tdata[2*FLD_W-1:FLD_W]);
    assign bn_m = fmag(s_tdata[3*FLD_W-1:2*FLD_W]);
    assign bd_m = fmag(s_tdata[4*FLD_W-1:3*FLD_W]);

    // operand magnitudes and signs held across the multiply steps
    logic [WIDTH:0] ad_r, bn_r, bd_r;
    logic           ans_r, ads_r, bns_r, bds_r;

    assign prod = ma_reg * mb_reg;

    assign dv_a = (state_reg == S_NSTART) ? num_reg :
                  (state_reg == S_DSTART) ? den_reg : gx_reg;
    assign dv_b = gx_reg;
    // no divider run once the remainder has reached zero
    assign dv_start = ((state_reg == S_GSTART) && (gy_reg != '0)) ||
                      (state_reg == S_NSTART) || (state_reg == S_DSTART);

    rfa_div #(.W(MW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  ((state_reg == S_GSTART) ? gx_reg : dv_a),
        .divisor   ((state_reg == S_GSTART) ? gy_reg : dv_b),
        .ctl       (dv_ctl),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    // signed combine of the first and second cross products, and sign of the reduced numerator
    always_comb
    begin
        t1 = p1_reg;
        n1 = p1n_reg;
        t2 = prod;
        n2 = (prod != '0) && ((bns_r ^ ads_r) ^ (op_reg == OP_SUB));
        if (n1 == n2)
        begin
            sum_mag = MW'(t1) + MW'(t2);
            sum_neg = n1;
        end
        else if (t1 >= t2)
        begin
            sum_mag = MW'(t1 - t2);
            sum_neg = n1;
        end
        else
        begin
            sum_mag = MW'(t2 - t1);
            sum_neg = n2;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
        sgn  = (nq_reg != '0) && (numn_reg != denn_reg);
        negn = sgn ? NUM_W'(0) - NUM_W'(nq_reg) : NUM_W'(nq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg <= s_tuser;
                        ad_r <= ad_m; bn_r <= bn_m; bd_r <= bd_m;
                        ans_r <= an_s; ads_r <= ad_s; bns_r <= bn_s; bds_r <= bd_s;
                        if (ad_m == '0 || bd_m == '0)
                        begin
                            rn_reg <= '0; rd_reg <= '0; st_reg <= ST_DENZERO;
                            state_reg <= S_OUT;
                        end
                        else if (s_tuser == OP_DIV && bn_m == '0)
                        begin
                            rn_reg <= '0; rd_reg <= '0; st_reg <= ST_DIVZERO;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ma_reg <= an_m;
                            mb_reg <= (s_tuser == OP_MUL) ? bn_m : bd_m;
                            state_reg <= S_MUL1;
                        end
                    end
                end
                S_MUL1:
                begin
                    // first product: an*bd, or an*bn for multiply
                    p1_reg  <= prod;
                    p1n_reg <= (prod != '0) &&
                               (ans_r ^ ((op_reg == OP_MUL) ? bns_r : bds_r));
                    ma_reg <= (op_reg == OP_ADD || op_reg == OP_SUB) ? bn_r : ad_r;
                    mb_reg <= (op_reg == OP_ADD || op_reg == OP_SUB) ? ad_r :
                              (op_reg == OP_DIV) ? bn_r : bd_r;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    if (op_reg == OP_ADD || op_reg == OP_SUB)
                    begin
                        num_reg  <= sum_mag;
                        numn_reg <= sum_neg;
                        ma_reg   <= ad_r;
                        mb_reg   <= bd_r;
                        state_reg <= S_MUL3;
                    end
                    else
                    begin
                        num_reg  <= MW'(p1_reg);
                        numn_reg <= p1n_reg;
                        den_reg  <= MW'(prod);
                        denn_reg <= ads_r ^ ((op_reg == OP_DIV) ? bns_r : bds_r);
                        gx_reg   <= MW'(p1_reg);
                        gy_reg   <= MW'(prod);
                        state_reg <= S_GSTART;
                    end
                end
                S_MUL3:
                begin
                    den_reg  <= MW'(prod);
                    denn_reg <= ads_r ^ bds_r;
                    gx_reg   <= num_reg;
                    gy_reg   <= MW'(prod);
                    state_reg <= S_GSTART;
                end
                S_GSTART:
                begin
                    if (gy_reg == '0)
                    begin
                        if (gx_reg == '0)
                            gx_reg <= MW'(1);
                        state_reg <= S_NSTART;
                    end
                    else
                        state_reg <= S_GWAIT;
                end
                S_GWAIT:
                begin
                    if (dv_ctl.done)
                    begin
                        gx_reg <= gy_reg;
                        gy_reg <= dv_r;
                        state_reg <= S_GSTART;
                    end
                end
                S_NSTART:
                    state_reg <= S_NWAIT;
                S_NWAIT:
                begin
                    if (dv_ctl.done)
                    begin
                        nq_reg <= dv_q;
                        state_reg <= S_DSTART;
                    end
                end
                S_DSTART:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (dv_ctl.done)
                    begin
                        rn_reg <= negn;
                        rd_reg <= (nq_reg == '0) ? DEN_W'(1) : DEN_W'(dv_q);
                        st_reg <= ST_OK;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {rd_reg, rn_reg};
    assign m_tuser  = st_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result waits");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        dv_start |-> !dv_ctl.busy)
        else $error("divider restarted while busy");
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[63:33] != '0))
        else $error("ok result with zero denominator");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped while stalled");
endmodule
